// File: src/aes_cmac_tag_unit_defines.svh
// Assertion helpers used by the RTL in aes_cmac_core.
`ifndef AES_CMAC_TAG_UNIT_DEFINES_SVH
`define AES_CMAC_TAG_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CMAC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define CMAC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CMAC_ASSERT(label, ante, cons, msg)
`define CMAC_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// File: src/aes_cmac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aes_cmac_pkg;

  typedef enum logic [1:0] {
    KIND_MID       = 2'd0,
    KIND_LAST_FULL = 2'd1,
    KIND_LAST_PART = 2'd2
  } kind_e;

  typedef struct packed {
    logic [127:0] blk;
    kind_e        kind;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } req_t;

  localparam logic [3:0] LAST_ROUND = 4'd10;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // byte i of a 128-bit block sits at [127-8i -: 8]
  function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
    get_byte = v[127 - 8 * i -: 8];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    unique case (r)
      4'd1:    rcon = 8'h01;
      4'd2:    rcon = 8'h02;
      4'd3:    rcon = 8'h04;
      4'd4:    rcon = 8'h08;
      4'd5:    rcon = 8'h10;
      4'd6:    rcon = 8'h20;
      4'd7:    rcon = 8'h40;
      4'd8:    rcon = 8'h80;
      4'd9:    rcon = 8'h1b;
      4'd10:   rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[127 - 8 * (i + 4 * c) -: 8] = SBOX[get_byte(s, i + 4 * ((c + i) % 4))];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] t);
    logic [127:0] m;
    logic [7:0]   a0, a1, a2, a3, all;
    m = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = get_byte(t, 4 * c);
      a1  = get_byte(t, 4 * c + 1);
      a2  = get_byte(t, 4 * c + 2);
      a3  = get_byte(t, 4 * c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      m[127 - 32 * c -: 8]  = a0 ^ all ^ xtime(a0 ^ a1);
      m[119 - 32 * c -: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
      m[111 - 32 * c -: 8]  = a2 ^ all ^ xtime(a2 ^ a3);
      m[103 - 32 * c -: 8]  = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_columns = m;
  endfunction

  function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, sr;
    w0 = rk[127:96];
    w1 = rk[95:64];
    w2 = rk[63:32];
    w3 = rk[31:0];
    sr = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ sr;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    key_step = {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] gf_double(input logic [127:0] v);
    gf_double = {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
  endfunction

endpackage
`default_nettype wire

// File: src/aes_cmac_front.sv
`timescale 1ns / 1ps
`default_nettype none
module aes_cmac_front #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic [127:0]         blk_i,
  input  wire logic [4:0]           valid_bytes_i,
  input  wire logic                 final_i,
  output      aes_cmac_pkg::req_t   req_o,
  input  wire logic                 pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(QueueDepth);

  aes_cmac_pkg::item_t queue_q [QueueDepth];
  aes_cmac_pkg::item_t item;
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push, pop;

  // classify: pad a short final block here so the back end only picks a subkey
  always_comb begin
    item.blk = blk_i;
    if (!final_i) begin
      item.kind = aes_cmac_pkg::KIND_MID;
    end else if (valid_bytes_i >= 5'd16) begin
      item.kind = aes_cmac_pkg::KIND_LAST_FULL;
    end else begin
      item.kind = aes_cmac_pkg::KIND_LAST_PART;
      for (int i = 0; i < 16; i++) begin
        if (5'(i) < valid_bytes_i) begin
          item.blk[127 - 8 * i -: 8] = blk_i[127 - 8 * i -: 8];
        end else if (5'(i) == valid_bytes_i) begin
          item.blk[127 - 8 * i -: 8] = 8'h80;
        end else begin
          item.blk[127 - 8 * i -: 8] = 8'h00;
        end
      end
    end
  end

  assign in_ready_o = (count_q != Full);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item;
    end
  end

  assign req_o.valid = (count_q != '0);
  assign req_o.item  = queue_q[rd_ptr_q];

endmodule
`default_nettype wire

// File: src/aes_cmac_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "aes_cmac_tag_unit_defines.svh"
module aes_cmac_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire aes_cmac_pkg::req_t req_i,
  output      logic               pop_o,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [127:0]       tag_o
);

  localparam logic CfgKeyUpper = 1'b0;
  localparam logic CfgKeyLower = 1'b1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StLoad = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [3:0]          rnd_q, rnd_d;
  logic                subkey_q, subkey_d;
  logic                open_q, open_d;
  logic                out_valid_q, out_valid_d;
  logic [63:0]         key_upper_q, key_lower_q;
  logic [127:0]        s_q, s_d, rk_q, rk_d, cv_q, cv_d, k1_q, k1_d, tag_q, tag_d;
  aes_cmac_pkg::item_t item_q, item_d;
  logic [127:0]        key, rk_n, t, s_n, x;
  logic                out_free;

  assign key      = {key_upper_q, key_lower_q};
  assign rk_n     = aes_cmac_pkg::key_step(rk_q, aes_cmac_pkg::rcon(rnd_q));
  assign t        = aes_cmac_pkg::sub_shift(s_q);
  assign s_n      = ((rnd_q == aes_cmac_pkg::LAST_ROUND) ? t : aes_cmac_pkg::mix_columns(t))
                    ^ rk_n;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (item_q.kind)
      aes_cmac_pkg::KIND_LAST_FULL: x = cv_q ^ item_q.blk ^ k1_q;
      aes_cmac_pkg::KIND_LAST_PART: x = cv_q ^ item_q.blk ^ aes_cmac_pkg::gf_double(k1_q);
      default:                      x = cv_q ^ item_q.blk;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    subkey_d    = subkey_q;
    open_d      = open_q;
    s_d         = s_q;
    rk_d        = rk_q;
    cv_d        = cv_q;
    k1_d        = k1_q;
    tag_d       = tag_q;
    item_d      = item_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          pop_o    = 1'b1;
          item_d   = req_i.item;
          subkey_d = !open_q;
          s_d      = open_q ? (cv_q ^ req_i.item.blk ^ key) : key;
          rk_d     = key;
          rnd_d    = 4'd1;
          state_d  = StRun;
          if (open_q && (req_i.item.kind != aes_cmac_pkg::KIND_MID)) begin
            state_d = StLoad;
          end
        end
      end
      StLoad: begin
        s_d     = x ^ key;
        rk_d    = key;
        rnd_d   = 4'd1;
        state_d = StRun;
      end
      StRun: begin
        if (rnd_q != aes_cmac_pkg::LAST_ROUND) begin
          s_d   = s_n;
          rk_d  = rk_n;
          rnd_d = rnd_q + 4'd1;
        end else if (subkey_q) begin
          k1_d     = aes_cmac_pkg::gf_double(s_n);
          cv_d     = '0;
          subkey_d = 1'b0;
          state_d  = StLoad;
        end else if (item_q.kind == aes_cmac_pkg::KIND_MID) begin
          cv_d    = s_n;
          open_d  = 1'b1;
          state_d = StIdle;
        end else if (out_free) begin
          tag_d       = s_n;
          out_valid_d = 1'b1;
          cv_d        = '0;
          open_d      = 1'b0;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rnd_q       <= '0;
      subkey_q    <= 1'b0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cv_q        <= '0;
      k1_q        <= '0;
      key_upper_q <= '0;
      key_lower_q <= '0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      subkey_q    <= subkey_d;
      open_q      <= open_d;
      out_valid_q <= out_valid_d;
      cv_q        <= cv_d;
      k1_q        <= k1_d;
      if (cfg_we_i && (cfg_index_i == CfgKeyUpper)) begin
        key_upper_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == CfgKeyLower)) begin
        key_lower_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    rk_q   <= rk_d;
    tag_q  <= tag_d;
    item_q <= item_d;
  end

  assign out_valid_o = out_valid_q;
  assign tag_o       = tag_q;

  `CMAC_ASSERT(a_rnd_range, state_q == StRun, (rnd_q >= 4'd1) && (rnd_q <= 4'd10), "round out of range")
  `CMAC_ASSERT(a_subkey_closed, (state_q == StRun) && subkey_q, !open_q, "subkey pass inside message")
  `CMAC_ASSERT(a_close_emits, $fell(open_q), out_valid_q, "message closed without a tag")
  `CMAC_ASSERT_NXT(a_pop_runs, pop_o, (state_q == StRun) || (state_q == StLoad), "pop without start")

endmodule
`default_nettype wire

// File: src/aes_cmac_tag_unit.sv
// Channel  | Dir | Handshake                 | Payload
// s_axis   | in  | s_axis_tvalid/tready      | tdata: block_upper, block_lower, valid_bytes;
//          |     |                           | tlast: final_block
// m_axis   | out | m_axis_tvalid/tready      | tdata: tag_upper, tag_lower
// cfg      | in  | cfg_valid/cfg_ready       | cfg_index (0 key_upper, 1 key_lower), cfg_data
//
// Each block runs through the iterative AES round unit (one round per cycle, round
// keys expanded on the fly; a last block's final round holds while a tag waits on tready);
// the first block of a message adds a K1 pass; a later last block adds a subkey load step.
// Up to QueueDepth blocks queue in front of the round unit, so the input keeps taking
// requests while a block is encrypted or a tag waits on m_axis_tready. cfg_ready is high.
// rst_ni clears key, chaining value, K1 and the queue asynchronously.
`timescale 1ns / 1ps
`default_nettype none
module aes_cmac_tag_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output      logic         s_axis_tready_o,
  // [63:0] block_upper, [127:64] block_lower, [132:128] valid_bytes, [135:133] zero
  input  wire logic [135:0] s_axis_tdata_i,
  input  wire logic         s_axis_tlast_i,
  output      logic         m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [63:0] tag_upper, [127:64] tag_lower
  output      logic [127:0] m_axis_tdata_o,
  input  wire logic         cfg_valid_i,
  output      logic         cfg_ready_o,
  input  wire logic         cfg_index_i,
  input  wire logic [63:0]  cfg_data_i
);

  aes_cmac_pkg::req_t req;
  logic               pop;
  logic [127:0]       tag;

  assign cfg_ready_o = 1'b1;

  aes_cmac_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .blk_i        ({s_axis_tdata_i[63:0], s_axis_tdata_i[127:64]}),
    .valid_bytes_i(s_axis_tdata_i[132:128]),
    .final_i      (s_axis_tlast_i),
    .req_o        (req),
    .pop_i        (pop)
  );

  aes_cmac_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .tag_o      (tag)
  );

  assign m_axis_tdata_o = {tag[63:0], tag[127:64]};

endmodule
`default_nettype wire

// File: bench/aes_cmac_tag_unit_test.sv
`timescale 1ns / 1ps
module aes_cmac_tag_unit_test;

  localparam bit KEY_UPPER = 1'b0;
  localparam bit KEY_LOWER = 1'b1;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [63:0] upper;
    logic [63:0] lower;
  } tag_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = KEY_UPPER;
  logic [63:0]  cfg_data = '0;

  // predictor state
  logic [127:0] aes_key = '0;
  logic [127:0] chain_val = '0;
  logic [127:0] subkey1 = '0;
  bit           msg_open = 1'b0;
  tag_t         tags_due[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  aes_cmac_tag_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] times_x(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] gf_times_x(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
  endfunction

  function automatic logic [127:0] aes128_encrypt(input logic [127:0] key,
                                                   input logic [127:0] pt);
    logic [7:0]   w[176];
    logic [7:0]   s[16];
    logic [7:0]   t[16];
    logic [7:0]   b0, b1, b2, b3, tmp, sum, rc;
    logic [127:0] ct;
    int           i, r, c;
    rc = 8'h01;
    for (i = 0; i < 16; i++) w[i] = key[127 - 8 * i -: 8];
    for (i = 16; i < 176; i += 4) begin
      b0 = w[i - 4]; b1 = w[i - 3]; b2 = w[i - 2]; b3 = w[i - 1];
      if (i % 16 == 0) begin
        tmp = b0;
        b0 = aes_cmac_pkg::SBOX[b1] ^ rc;
        b1 = aes_cmac_pkg::SBOX[b2];
        b2 = aes_cmac_pkg::SBOX[b3];
        b3 = aes_cmac_pkg::SBOX[tmp];
        rc = times_x(rc);
      end
      w[i] = w[i - 16] ^ b0;
      w[i + 1] = w[i - 15] ^ b1;
      w[i + 2] = w[i - 14] ^ b2;
      w[i + 3] = w[i - 13] ^ b3;
    end
    for (i = 0; i < 16; i++) s[i] = pt[127 - 8 * i -: 8] ^ w[i];
    for (r = 1; r <= 10; r++) begin
      for (c = 0; c < 4; c++)
        for (i = 0; i < 4; i++) t[i + 4 * c] = aes_cmac_pkg::SBOX[s[i + 4 * ((c + i) % 4)]];
      if (r < 10) begin
        for (c = 0; c < 4; c++) begin
          b0 = t[4 * c]; b1 = t[4 * c + 1]; b2 = t[4 * c + 2]; b3 = t[4 * c + 3];
          sum = b0 ^ b1 ^ b2 ^ b3;
          t[4 * c] = b0 ^ sum ^ times_x(b0 ^ b1);
          t[4 * c + 1] = b1 ^ sum ^ times_x(b1 ^ b2);
          t[4 * c + 2] = b2 ^ sum ^ times_x(b2 ^ b3);
          t[4 * c + 3] = b3 ^ sum ^ times_x(b3 ^ b0);
        end
      end
      for (i = 0; i < 16; i++) s[i] = t[i] ^ w[16 * r + i];
    end
    for (i = 0; i < 16; i++) ct[127 - 8 * i -: 8] = s[i];
    return ct;
  endfunction

  task automatic predict_tag(input logic [63:0] upper, input logic [63:0] lower,
                             input logic [4:0] vb, input bit fin);
    logic [127:0] blk, x, subkey2;
    tag_t         tag;
    int           i;
    blk = {upper, lower};
    if (!msg_open) begin
      subkey1 = gf_times_x(aes128_encrypt(aes_key, '0));
      chain_val = '0;
    end
    if (!fin) begin
      chain_val = aes128_encrypt(aes_key, chain_val ^ blk);
      msg_open = 1'b1;
    end else begin
      if (vb >= 5'd16) begin
        x = blk ^ subkey1;
      end else begin
        subkey2 = gf_times_x(subkey1);
        for (i = 0; i < 16; i++)
          x[127 - 8 * i -: 8] = (i < vb) ? blk[127 - 8 * i -: 8] : (i == vb ? 8'h80 : 8'h00);
        x = x ^ subkey2;
      end
      x = aes128_encrypt(aes_key, x ^ chain_val);
      tag.upper = x[127:64];
      tag.lower = x[63:0];
      tags_due.push_back(tag);
      chain_val = '0;
      msg_open = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // result checker
  always @(posedge clk_i) begin
    tag_t exp_tag;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tags_due.size() == 0) begin
        report_mismatch($sformatf("unexpected tag %h", m_axis_tdata));
      end else begin
        exp_tag = tags_due.pop_front();
        if (m_axis_tdata[63:0] !== exp_tag.upper)
          report_mismatch($sformatf("tag_upper %h, want %h", m_axis_tdata[63:0], exp_tag.upper));
        if (m_axis_tdata[127:64] !== exp_tag.lower)
          report_mismatch($sformatf("tag_lower %h, want %h", m_axis_tdata[127:64],
                                    exp_tag.lower));
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_block(input logic [63:0] upper, input logic [63:0] lower,
                            input logic [4:0] vb, input bit fin);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, vb, lower, upper};
    s_axis_tlast <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_tag(upper, lower, vb, fin);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_message(input int blocks, input logic [4:0] last_vb);
    for (int i = 0; i < blocks; i++)
      send_block(rand64(), rand64(), 5'($urandom_range(31)), 1'b0);
    send_block(rand64(), rand64(), last_vb, 1'b1);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (tags_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_key(input logic [63:0] upper, input logic [63:0] lower);
    cfg_valid <= 1'b1;
    cfg_index <= KEY_UPPER;
    cfg_data <= upper;
    do @(posedge clk_i); while (!cfg_ready);
    aes_key[127:64] = upper;
    cfg_index <= KEY_LOWER;
    cfg_data <= lower;
    do @(posedge clk_i); while (!cfg_ready);
    aes_key[63:0] = lower;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_message(0, 5'd0);
    send_message(0, 5'd16);
    send_block('0, '0, 5'd7, 1'b1);
    send_block('1, '1, 5'd16, 1'b1);
    send_block('1, '1, 5'd31, 1'b1);
    send_block('1, '1, 5'd15, 1'b1);
    send_block('1, '1, 5'd1, 1'b1);
    send_block('1, '1, 5'd31, 1'b0);
    send_block('0, '0, 5'd0, 1'b1);
    send_block('0, '0, 5'd5, 1'b0);
    send_block('1, '0, 5'd8, 1'b1);
    send_message(2, 5'd17);
    send_message(1, 5'd9);
    wait_idle();
  endtask

  task automatic test_keys();
    write_key('1, '1);
    send_message(1, 5'd16);
    send_message(0, 5'd0);
    wait_idle();
    write_key('0, '1);
    send_message(2, 5'd3);
    wait_idle();
    write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_message(0, 5'd0);
    send_message(0, 5'd16);
    wait_idle();
  endtask

  task automatic test_random(input int items, input int idle_pct, input int stall_pct);
    int sent, blocks;
    logic [4:0] vb;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    write_key(rand64(), rand64());
    while (sent < items) begin
      blocks = ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
      case ($urandom_range(3))
        0: vb = 5'd16;
        1: vb = 5'd0;
        default: vb = 5'($urandom_range(31));
      endcase
      send_message(blocks, vb);
      sent += blocks + 1;
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) send_message($urandom_range(0, 2), 5'($urandom_range(31)));
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_keys();
    test_random(400, 0, 0);
    test_random(350, 81, 0);
    test_random(350, 0, 81);
    test_random(400, 32, 32);
    test_backpressure();
    if (errors == 0) begin
      $display("aes_cmac_tag_unit_test OK");
    end else begin
      $display("aes_cmac_tag_unit_test NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("aes_cmac_tag_unit_test NOT OK");
    $finish;
  end

endmodule
